FILE: design/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants of the packet CRC filter: item structs,
// CRC-16 CCITT constants and packet length limits.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int unsigned LEN_W = 9;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [LEN_W-1:0] LEN_MIN   = 9'd3;
    localparam logic [LEN_W-1:0] LEN_MAX   = 9'd258;
    localparam logic [LEN_W-1:0] LEN_RESET = 9'd3;

    typedef struct packed {
        logic msc_bit;
        logic frame_end;
    } pcf_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_end;
        logic       crc_ok;
    } pcf_out_t;

endpackage

FILE: design/pcf_core.sv
// ----------------------------------------------------------------------------
// pcf_core
// Bit packer and bit-serial CRC-16 checker. Holds the packet state and
// updates it by one bit per processed item; the result is combinational.
// ----------------------------------------------------------------------------
module pcf_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  pcf_pkg::pcf_in_t          item,
    input  logic [pcf_pkg::LEN_W-1:0] packet_length,
    output logic                      res_valid,
    output pcf_pkg::pcf_out_t         res
);
    import pcf_pkg::*;

    logic [7:0]       bit_shift_reg;
    logic [7:0]       bit_shift_next;
    logic [2:0]       bit_count_reg;
    logic [2:0]       bit_count_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [LEN_W-1:0] byte_count_reg;
    logic [LEN_W-1:0] byte_count_next;

    logic [LEN_W-1:0] len;
    logic             inv;
    logic             fb;
    logic [15:0]      crc_shifted;
    logic [7:0]       shift_new;
    logic             byte_done;
    logic             last;

    // clamp the length into the supported range
    always_comb
    begin
        if (packet_length < LEN_MIN)
            len = LEN_MIN;
        else if (packet_length > LEN_MAX)
            len = LEN_MAX;
        else
            len = packet_length;
    end

    // invert the two trailing CRC bytes before they enter the register
    assign inv         = (byte_count_reg >= (len - LEN_W'(2)));
    assign fb          = crc_reg[15] ^ item.msc_bit ^ inv;
    assign crc_shifted = {crc_reg[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    assign shift_new   = {bit_shift_reg[6:0], item.msc_bit};
    assign byte_done   = (bit_count_reg == 3'd7);
    assign last        = ({1'b0, byte_count_reg} + 10'd1) >= {1'b0, len};

    assign res_valid      = byte_done;
    assign res.data_byte  = shift_new;
    assign res.packet_end = last;
    assign res.crc_ok     = last && (crc_shifted == 16'h0000);

    always_comb
    begin
        bit_shift_next  = bit_shift_reg;
        bit_count_next  = bit_count_reg;
        crc_next        = crc_reg;
        byte_count_next = byte_count_reg;
        if (go)
        begin
            bit_shift_next = shift_new;
            bit_count_next = bit_count_reg + 3'd1;
            crc_next       = crc_shifted;
            if (byte_done)
            begin
                bit_shift_next = 8'h00;
                if (last)
                begin
                    crc_next        = CRC_INIT;
                    byte_count_next = '0;
                end
                else
                begin
                    byte_count_next = byte_count_reg + LEN_W'(1);
                end
            end
            // drop the partial byte and packet at frame end
            if (item.frame_end)
            begin
                bit_shift_next  = 8'h00;
                bit_count_next  = 3'd0;
                crc_next        = CRC_INIT;
                byte_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_shift_reg  <= 8'h00;
            bit_count_reg  <= 3'd0;
            crc_reg        <= CRC_INIT;
            byte_count_reg <= '0;
        end
        else
        begin
            bit_shift_reg  <= bit_shift_next;
            bit_count_reg  <= bit_count_next;
            crc_reg        <= crc_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // a packet never grows past the largest length
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < LEN_MAX)
        else $error("pcf_core: byte count beyond maximum packet length");

    // a finished byte always clears the packing register
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && byte_done) |=> (bit_shift_reg == 8'h00 && bit_count_reg == 3'd0))
        else $error("pcf_core: packer not cleared after byte");

    // frame end restarts the CRC
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && item.frame_end) |=> (crc_reg == CRC_INIT && byte_count_reg == '0))
        else $error("pcf_core: packet state not cleared at frame end");

endmodule

FILE: design/packet_crc_filter.sv
// ----------------------------------------------------------------------------
// packet_crc_filter
// Packs a serial bit stream into bytes, cuts them into packets and checks
// each packet with CRC-16 CCITT, flagging the verdict on its last byte.
// ----------------------------------------------------------------------------
// Path: a byte completed by an input bit passes the input register, then the
//   result register, before it is on the output.
// Throughput: one input bit per cycle while the output is not stalled; the
//   CRC and packer update lies combinationally between the two registers.
// Reset: packet length 3, CRC 0xFFFF, packer and byte count cleared,
//   both pipeline registers empty.
module packet_crc_filter
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [pcf_pkg::LEN_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  pcf_pkg::pcf_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output pcf_pkg::pcf_out_t         out_data
);
    import pcf_pkg::*;

    logic [LEN_W-1:0] packet_length_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    pcf_in_t          in_item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    pcf_out_t         out_data_reg;

    logic             out_ready;
    logic             proc_go;
    logic             in_xfer;
    logic             res_valid;
    pcf_out_t         res;

    assign out_ready = !out_valid_reg || !out_stall;
    assign proc_go   = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign in_xfer   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            packet_length_reg <= LEN_RESET;
        else if (cfg_write)
            packet_length_reg <= cfg_data;
    end

    always_comb
    begin
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (proc_go)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        if (out_ready)
            out_valid_next = proc_go && res_valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payloads while their stage waits
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_item_reg <= in_data;
        if (out_ready && proc_go && res_valid)
            out_data_reg <= res;
    end

    pcf_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (proc_go),
        .item          (in_item_reg),
        .packet_length (packet_length_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // a finished byte is never lost on its way to the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && res_valid) |=> out_valid_reg)
        else $error("packet_crc_filter: completed byte not registered");

    // a pass verdict only comes with the last byte of a packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.crc_ok) |-> out_data_reg.packet_end)
        else $error("packet_crc_filter: crc_ok without packet_end");

    // a waiting input item is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_go) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("packet_crc_filter: pending input item lost");

endmodule

FILE: verif/tb_packet_crc_filter.sv
// ----------------------------------------------------------------------------
// tb_packet_crc_filter
// Self-checking bench for the packet CRC filter. A queue-fed driver sends
// bit transfers, a bit-level packer/CRC predictor builds the expected
// bytes, and a monitor compares each output transfer with the oldest one.
// Stimulus mixes well-formed CRC packets, corrupted packets, noise and frame
// ends across several packet length settings, including out-of-range ones.
// ----------------------------------------------------------------------------
module tb_packet_crc_filter;

    timeunit 1ns;
    timeprecision 1ps;

    import pcf_pkg::*;

    localparam int IDLE_PCT     = 22;
    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SHOW_ERRORS  = 10;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_write = 1'b0;
    logic [LEN_W-1:0]   cfg_data  = LEN_RESET;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    pcf_in_t            in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pcf_out_t           out_data;

    pcf_in_t            pending_bits[$];
    pcf_out_t           expected_bytes[$];
    int                 bits_queued = 0;
    int                 bits_taken  = 0;
    int                 err_count   = 0;
    int                 cycles      = 0;
    bit                 calm        = 1'b0;

    // predictor state
    logic [LEN_W-1:0]   length_reg  = LEN_RESET;
    logic [7:0]         pk_shift    = '0;
    logic [2:0]         pk_bits     = '0;
    logic [15:0]        pk_crc      = CRC_INIT;
    logic [LEN_W-1:0]   pk_bytes    = '0;

    packet_crc_filter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [LEN_W-1:0] effective_len(logic [LEN_W-1:0] v);
        if (v < LEN_MIN)
            return LEN_MIN;
        if (v > LEN_MAX)
            return LEN_MAX;
        return v;
    endfunction

    // Advance the packer and CRC by one accepted bit; record any completed byte.
    function automatic void advance_packer(pcf_in_t it);
        logic [LEN_W-1:0] len;
        logic             inv;
        logic             fb;
        logic             last;
        pcf_out_t         r;
        len = effective_len(length_reg);
        inv = (pk_bytes >= len - 9'd2);
        fb = pk_crc[15] ^ it.msc_bit ^ inv;
        pk_crc = {pk_crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        pk_shift = {pk_shift[6:0], it.msc_bit};
        pk_bits = pk_bits + 3'd1;
        if (pk_bits == 3'd0)
        begin
            last = ({1'b0, pk_bytes} + 10'd1 >= {1'b0, len});
            r.data_byte  = pk_shift;
            r.packet_end = last;
            r.crc_ok     = last && (pk_crc == 16'h0000);
            expected_bytes.push_back(r);
            pk_shift = '0;
            if (last)
            begin
                pk_crc   = CRC_INIT;
                pk_bytes = '0;
            end
            else
                pk_bytes = pk_bytes + 9'd1;
        end
        // frame end drops the partial byte and packet
        if (it.frame_end)
        begin
            pk_shift = '0;
            pk_bits  = '0;
            pk_crc   = CRC_INIT;
            pk_bytes = '0;
        end
    endfunction

    function automatic logic [15:0] crc_of_byte(logic [15:0] c, logic [7:0] b);
        for (int i = 7; i >= 0; i--)
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[i]) ? CRC_POLY : 16'h0000);
        return c;
    endfunction

    task automatic queue_bit(input logic b, input logic fe);
        pcf_in_t it;
        it.msc_bit   = b;
        it.frame_end = fe;
        pending_bits.push_back(it);
        bits_queued++;
    endtask

    task automatic queue_byte(input logic [7:0] v, input logic fe);
        for (int i = 7; i >= 0; i--)
            queue_bit(v[i], fe && (i == 0));
    endtask

    task automatic queue_noise(input int n, input logic fe);
        for (int i = 0; i < n; i++)
            queue_bit(1'($urandom_range(1)), fe && (i == n - 1));
    endtask

    task automatic queue_random_bytes(input int n, input logic fe);
        for (int i = 0; i < n; i++)
            queue_byte(8'($urandom), fe && (i == n - 1));
    endtask

    // Payload plus the inverted CRC, so an unbroken packet checks clean.
    task automatic queue_packet(input int nbytes, input logic corrupt, input logic fe);
        logic [7:0]  pkt[$];
        logic [15:0] c;
        int          pos;
        c = CRC_INIT;
        for (int k = 0; k < nbytes - 2; k++)
        begin
            pkt.push_back(8'($urandom));
            c = crc_of_byte(c, pkt[k]);
        end
        pkt.push_back(~c[15:8]);
        pkt.push_back(~c[7:0]);
        if (corrupt)
        begin
            pos = $urandom_range(nbytes - 1);
            pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(7));
        end
        for (int k = 0; k < nbytes; k++)
            queue_byte(pkt[k], fe && (k == nbytes - 1));
    endtask

    task automatic set_packet_length(input logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        length_reg = v;
        @(negedge clk);
    endtask

    // Wait until every bit is taken and every byte seen, then let the pipe empty.
    task automatic drain();
        while (bits_taken != bits_queued || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_packer(in_data);
                bits_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bits.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_data  <= pending_bits.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        pcf_out_t exp_byte;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    err_count++;
                    if (err_count <= SHOW_ERRORS)
                        $display("unexpected byte transfer: data %02h end %0b ok %0b",
                                 out_data.data_byte, out_data.packet_end, out_data.crc_ok);
                end
                else
                begin
                    exp_byte = expected_bytes.pop_front();
                    if (out_data.data_byte !== exp_byte.data_byte
                        || out_data.packet_end !== exp_byte.packet_end
                        || out_data.crc_ok !== exp_byte.crc_ok)
                    begin
                        err_count++;
                        if (err_count <= SHOW_ERRORS)
                            $display("byte mismatch: exp data %02h end %0b ok %0b, got data %02h end %0b ok %0b",
                                     exp_byte.data_byte, exp_byte.packet_end, exp_byte.crc_ok,
                                     out_data.data_byte, out_data.packet_end, out_data.crc_ok);
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("packet_crc_filter regression: fail");
            $finish;
        end
    end

    initial
    begin
        int               start_count;
        int               r;
        int               nfr;
        int               npk;
        int               fe_mode;
        logic             fe;
        logic [LEN_W-1:0] lenv;
        int               eff;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // clean packet at reset length ending on a frame end, then a lone marked bit
        queue_packet(int'(LEN_RESET), 1'b0, 1'b1);
        queue_bit(1'b1, 1'b1);
        drain();

        // shrink the length under a packet that already holds more bytes
        set_packet_length(9'd10);
        queue_random_bytes(5, 1'b0);
        drain();
        set_packet_length(LEN_MIN);
        queue_byte(8'($urandom), 1'b1);
        drain();

        // long packet, sent back to back with no idling
        calm = 1'b1;
        set_packet_length(9'd64);
        queue_packet(64, 1'b0, 1'b1);
        drain();
        calm = 1'b0;

        // register maximum clamps to the longest length
        set_packet_length(9'h1FF);
        queue_random_bytes(3, 1'b0);
        queue_noise(13, 1'b1);
        drain();

        start_count = bits_queued;
        while (bits_queued - start_count < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 70)
                lenv = 9'($urandom_range(3, 10));
            else if (r < 82)
                lenv = 9'($urandom_range(11, 40));
            else if (r < 91)
                lenv = 9'($urandom_range(0, 2));
            else
                lenv = 9'($urandom_range(259, 511));
            set_packet_length(lenv);
            eff = int'(effective_len(lenv));

            nfr = $urandom_range(1, 4);
            for (int f = 0; f < nfr; f++)
            begin
                if (eff > 40)
                begin
                    queue_noise($urandom_range(1, 60), 1'b1);
                    continue;
                end
                npk = $urandom_range(1, 3);
                fe_mode = $urandom_range(2);
                for (int p = 0; p < npk; p++)
                begin
                    fe = (p == npk - 1) && (fe_mode == 0);
                    r = $urandom_range(99);
                    if (r < 75)
                        queue_packet(eff, $urandom_range(99) < 25, fe);
                    else if (r < 88)
                        queue_random_bytes($urandom_range(1, eff), fe);
                    else
                        queue_noise($urandom_range(1, 12), fe);
                end
                // mark the frame end on an extra bit
                if (fe_mode == 1)
                    queue_bit(1'($urandom_range(1)), 1'b1);
            end
            drain();
        end

        drain();
        if (err_count == 0)
            $display("packet_crc_filter regression: pass");
        else
            $display("packet_crc_filter regression: fail");
        $finish;
    end

endmodule
